// File: hw/rtl/atb_block_run_mapper_unit_defines.svh
// assertion macros shared by the block run mapper checkers
`ifndef ATB_BLOCK_RUN_MAPPER_UNIT_DEFINES_SVH
`define ATB_BLOCK_RUN_MAPPER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define ATBRM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define ATBRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/atbrm_pkg.sv
// shared types, constants and helpers of the block run mapper
package atbrm_pkg;

    localparam int LIST_DEPTH_DEF    = 32;
    localparam int TABLE_ENTRIES_DEF = 192;

    localparam int BLOCK_W    = 16;
    localparam int PAGE_W     = 18;
    localparam int IDX_W      = 8;
    localparam int MODE_W     = 9;
    localparam int KIND_W     = 2;
    localparam int EXP_W      = 5;
    localparam int LEN_W      = 6;
    localparam int LIMIT_W    = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_PAGE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIST_LIMIT = 2'd1;

    localparam logic [MODE_W-1:0] MODE_FIRST = 9'h130;
    localparam logic [MODE_W-1:0] MODE_BASE  = 9'h030;

    localparam logic [EXP_W-1:0]     EXP_MAX       = 5'd17;
    localparam logic [PAGE_W-1:0]    BASE_PAGE_RST = 18'd1;
    localparam logic [LIMIT_W-1:0]   LIMIT_RST     = 6'd32;

    // one step of the run walk: compare a stored block with its successor
    typedef struct packed {
        logic [BLOCK_W-1:0] prev;
        logic [BLOCK_W-1:0] cur;
        logic [LEN_W-1:0]   len;
        logic [EXP_W-1:0]   e;
        logic [EXP_W-1:0]   maxe;
        logic               more;
    } step_in_t;

    typedef struct packed {
        logic             go;
        logic [LEN_W-1:0] len;
        logic [EXP_W-1:0] e;
    } step_out_t;

    // trailing zero count of a page, saturating at 17
    function automatic logic [EXP_W-1:0] align_exp(input logic [PAGE_W-1:0] page);
        logic [EXP_W-1:0] e;
        e = EXP_MAX;
        for (int k = 16; k >= 0; k--)
        begin
            if (page[k])
            begin
                e = EXP_W'(k);
            end
        end
        return e;
    endfunction

endpackage

// File: hw/rtl/atbrm_ifs.sv
// valid/ready channel interfaces of the block run mapper
interface atbrm_block_if
    import atbrm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] block_number;

    modport source (output valid, output block_number, input ready);
    modport sink   (input valid, input block_number, output ready);
endinterface

interface atbrm_result_if
    import atbrm_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [IDX_W-1:0]   entry_index;
    logic [BLOCK_W-1:0] phys_block;
    logic [PAGE_W-1:0]  virt_page;
    logic [MODE_W-1:0]  mode_word;
    logic [IDX_W-1:0]   fill_count;
    logic               last;

    modport source (output valid, output kind, output entry_index, output phys_block,
                    output virt_page, output mode_word, output fill_count, output last,
                    input ready);
    modport sink   (input valid, input kind, input entry_index, input phys_block,
                    input virt_page, input mode_word, input fill_count, input last,
                    output ready);
endinterface

interface atbrm_cfg_if
    import atbrm_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/atbrm_store.sv
// block list buffer: one write port, one registered read port
module atbrm_store
    import atbrm_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic               clk,
    input  logic               wr_en,
    input  logic [AW-1:0]      wr_addr,
    input  logic [BLOCK_W-1:0] wr_data,
    input  logic [AW-1:0]      rd_addr,
    output logic [BLOCK_W-1:0] rd_data
);

    logic [BLOCK_W-1:0] mem [DEPTH];
    logic [BLOCK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hw/rtl/atbrm_step.sv
// shared run-walk unit: successor compare, run length and size exponent update
module atbrm_step
    import atbrm_pkg::*;
(
    input  step_in_t  step_i,
    output step_out_t step_o
);

    logic             chain;
    logic             go;
    logic [LEN_W:0]   len_nx;
    logic [LEN_W:0]   mask;

    assign chain  = ({1'b0, step_i.prev} + 17'd1) == {1'b0, step_i.cur};
    assign go     = step_i.more && (step_i.e < step_i.maxe) && chain;
    assign len_nx = {1'b0, step_i.len} + (LEN_W+1)'(1);
    // low e+1 bits of the new length all zero: run doubled
    assign mask   = ({{(LEN_W-1){1'b0}}, 2'b10} << step_i.e) - (LEN_W+1)'(1);

    always_comb
    begin
        step_o.go  = go;
        step_o.len = go ? len_nx[LEN_W-1:0] : step_i.len;
        step_o.e   = (go && ((len_nx & mask) == '0)) ? step_i.e + EXP_W'(1) : step_i.e;
    end

endmodule

// File: hw/rtl/atb_block_run_mapper_unit.sv
// top level of the block run mapper: sequencer, config registers, result register
//
// channels: blocks (sink) takes one 16-bit block number per item; a zero item
// ends the list. results (source) carries translation table writes: entry 0,
// one entry per greedy power-of-two run, then one fill record; last marks the
// final item of a run. cfg (sink, always ready) writes base_page (index 0) and
// list_limit (index 1); write it only while the block is idle.
// a nonzero block is stored and gives no result. the terminator puts
// entry 0 in the result register on the next edge; each run then passes
// through the head state, one walk compare per block it checks through the
// shared step unit, and the emit state, and the fill record follows the last
// run.
// the single read port of the list buffer paces the walk: one stored block per
// cycle. blocks.ready is low from the terminator until the last result is
// taken and while any result waits in the output register.
// overflow or base page zero gives one failure item and clears the list.
// reset: base_page 1, list_limit 32, empty list; the buffer itself is not
// cleared, only its fill count. a stalled receiver freezes the sequencer at
// its next emit; the result register holds its item until taken.
module atb_block_run_mapper_unit
    import atbrm_pkg::*;
#(
    parameter int LIST_DEPTH    = LIST_DEPTH_DEF,
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    atbrm_block_if.sink    blocks,
    atbrm_result_if.source results,
    atbrm_cfg_if.sink      cfg
);

    localparam int CW    = $clog2(LIST_DEPTH);
    localparam int TW    = 9;
    localparam int SUM_W = PAGE_W + 1;

    localparam logic [2:0] S_LOAD = 3'd0;
    localparam logic [2:0] S_HEAD = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_FILL = 3'd4;

    localparam logic [TW-1:0] TE = TW'(TABLE_ENTRIES);

    // control state
    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [TW-1:0]       tidx_reg, tidx_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [CW-1:0]       rs_reg, rs_next;
    logic [PAGE_W-1:0]   base_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic                out_valid_reg, out_valid_next;

    // run walk payload
    logic [CW-1:0]       i_reg, i_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [EXP_W-1:0]    e_reg, e_next;
    logic [EXP_W-1:0]    maxe_reg, maxe_next;
    logic [BLOCK_W-1:0]  prev_reg, prev_next;
    logic [BLOCK_W-1:0]  phys_reg, phys_next;
    logic [BLOCK_W-1:0]  first_reg, first_next;

    // result register payload
    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [BLOCK_W-1:0]  ophys_reg, ophys_next;
    logic [PAGE_W-1:0]   opage_reg, opage_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [IDX_W-1:0]    fcnt_reg, fcnt_next;
    logic                last_reg, last_next;

    logic                in_ready;
    logic                out_free;
    logic [LIMIT_W-1:0]  lim;
    logic                wr_en;
    logic [SUM_W-1:0]    rd_idx;
    logic [CW-1:0]       rd_addr;
    logic [BLOCK_W-1:0]  rd_data;
    logic [SUM_W-1:0]    rs_sum;
    logic                emit_en;
    step_in_t            step_i;
    step_out_t           step_o;

    atbrm_store #(
        .DEPTH (LIST_DEPTH),
        .AW    (CW)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg),
        .wr_data (blocks.block_number),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    atbrm_step u_step (
        .step_i (step_i),
        .step_o (step_o)
    );

    assign in_ready     = (state_reg == S_LOAD) && !out_valid_reg;
    assign blocks.ready = in_ready;
    assign cfg.ready    = 1'b1;
    assign out_free     = !out_valid_reg || results.ready;

    // effective list limit clamped to [1, LIST_DEPTH]
    always_comb
    begin
        if (limit_reg == '0)
        begin
            lim = LIMIT_W'(1);
        end
        else if (limit_reg > LIMIT_W'(LIST_DEPTH))
        begin
            lim = LIMIT_W'(LIST_DEPTH);
        end
        else
        begin
            lim = limit_reg;
        end
    end

    // shared step unit operands: stored block i and its successor
    always_comb
    begin
        step_i.prev = prev_reg;
        step_i.cur  = rd_data;
        step_i.len  = len_reg;
        step_i.e    = e_reg;
        step_i.maxe = maxe_reg;
        step_i.more = ({1'b0, i_reg} + (CW+1)'(1)) < {1'b0, count_reg};
    end

    assign rs_sum  = SUM_W'(rs_reg) + (SUM_W'(1) << e_reg);
    assign emit_en = tidx_reg < TE;
    assign rd_addr = (rd_idx < SUM_W'(LIST_DEPTH)) ? rd_idx[CW-1:0] : '0;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        tidx_next      = tidx_reg;
        page_next      = page_reg;
        rs_next        = rs_reg;
        out_valid_next = out_valid_reg && !results.ready;
        i_next         = i_reg;
        len_next       = len_reg;
        e_next         = e_reg;
        maxe_next      = maxe_reg;
        prev_next      = prev_reg;
        phys_next      = phys_reg;
        first_next     = first_reg;
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        ophys_next     = ophys_reg;
        opage_next     = opage_reg;
        mode_next      = mode_reg;
        fcnt_next      = fcnt_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        rd_idx         = '0;

        case (state_reg)
            S_LOAD:
            begin
                if (blocks.valid && in_ready)
                begin
                    if ((blocks.block_number != '0) &&
                        ({{(LIMIT_W-CW){1'b0}}, count_reg} < lim - LIMIT_W'(1)))
                    begin
                        // store the block
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                        if (count_reg == '0)
                        begin
                            first_next = blocks.block_number;
                        end
                    end
                    else if ((blocks.block_number != '0) || (base_reg == '0))
                    begin
                        // list overflow or missing base page
                        out_valid_next = 1'b1;
                        kind_next      = KIND_FAIL;
                        idx_next       = '0;
                        ophys_next     = '0;
                        opage_next     = '0;
                        mode_next      = '0;
                        fcnt_next      = '0;
                        last_next      = 1'b1;
                        count_next     = '0;
                        tidx_next      = TW'(1);
                        page_next      = '0;
                        rs_next        = '0;
                    end
                    else
                    begin
                        // terminator: entry 0 maps the page before the base
                        out_valid_next = 1'b1;
                        kind_next      = KIND_ENTRY;
                        idx_next       = '0;
                        ophys_next     = '0;
                        opage_next     = base_reg - PAGE_W'(1);
                        mode_next      = MODE_FIRST;
                        fcnt_next      = '0;
                        last_next      = 1'b0;
                        tidx_next      = TW'(1);
                        page_next      = base_reg;
                        rs_next        = '0;
                        rd_idx         = '0;
                        state_next     = S_HEAD;
                    end
                end
            end

            S_HEAD:
            begin
                // first block of the run is in the read register
                maxe_next  = align_exp(page_reg);
                phys_next  = (rs_reg < count_reg) ? rd_data : '0;
                prev_next  = rd_data;
                len_next   = LEN_W'(1);
                e_next     = '0;
                i_next     = rs_reg;
                rd_idx     = SUM_W'(rs_reg) + SUM_W'(1);
                state_next = S_WALK;
            end

            S_WALK:
            begin
                len_next = step_o.len;
                e_next   = step_o.e;
                if (step_o.go)
                begin
                    i_next    = i_reg + CW'(1);
                    prev_next = rd_data;
                    rd_idx    = SUM_W'(i_reg) + SUM_W'(2);
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_EMIT:
            begin
                rd_idx = rs_sum;
                if (!emit_en || out_free)
                begin
                    if (emit_en)
                    begin
                        out_valid_next = 1'b1;
                        kind_next      = KIND_ENTRY;
                        idx_next       = tidx_reg[IDX_W-1:0];
                        ophys_next     = phys_reg;
                        opage_next     = page_reg;
                        mode_next      = MODE_BASE | MODE_W'(e_reg);
                        fcnt_next      = '0;
                        last_next      = (tidx_reg == TE - TW'(1));
                    end
                    tidx_next = tidx_reg + TW'(1);
                    page_next = page_reg + (PAGE_W'(1) << e_reg);
                    if (rs_sum < SUM_W'(count_reg))
                    begin
                        rs_next    = rs_sum[CW-1:0];
                        state_next = S_HEAD;
                    end
                    else if (tidx_reg + TW'(1) < TE)
                    begin
                        state_next = S_FILL;
                    end
                    else
                    begin
                        count_next = '0;
                        tidx_next  = TW'(1);
                        page_next  = '0;
                        rs_next    = '0;
                        state_next = S_LOAD;
                    end
                end
            end

            S_FILL:
            begin
                if (out_free)
                begin
                    // remaining entries map the first block at the final page
                    out_valid_next = 1'b1;
                    kind_next      = KIND_FILL;
                    idx_next       = tidx_reg[IDX_W-1:0];
                    ophys_next     = (count_reg != '0) ? first_reg : '0;
                    opage_next     = page_reg;
                    mode_next      = MODE_BASE;
                    fcnt_next      = IDX_W'(TE - tidx_reg);
                    last_next      = 1'b1;
                    count_next     = '0;
                    tidx_next      = TW'(1);
                    page_next      = '0;
                    rs_next        = '0;
                    state_next     = S_LOAD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            tidx_reg      <= TW'(1);
            page_reg      <= '0;
            rs_reg        <= '0;
            out_valid_reg <= 1'b0;
            base_reg      <= BASE_PAGE_RST;
            limit_reg     <= LIMIT_RST;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            tidx_reg      <= tidx_next;
            page_reg      <= page_next;
            rs_reg        <= rs_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_BASE_PAGE:  base_reg  <= cfg.data[PAGE_W-1:0];
                    REG_LIST_LIMIT: limit_reg <= cfg.data[LIMIT_W-1:0];
                    default:        ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg     <= i_next;
        len_reg   <= len_next;
        e_reg     <= e_next;
        maxe_reg  <= maxe_next;
        prev_reg  <= prev_next;
        phys_reg  <= phys_next;
        first_reg <= first_next;
        kind_reg  <= kind_next;
        idx_reg   <= idx_next;
        ophys_reg <= ophys_next;
        opage_reg <= opage_next;
        mode_reg  <= mode_next;
        fcnt_reg  <= fcnt_next;
        last_reg  <= last_next;
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = kind_reg;
    assign results.entry_index = idx_reg;
    assign results.phys_block  = ophys_reg;
    assign results.virt_page   = opage_reg;
    assign results.mode_word   = mode_reg;
    assign results.fill_count  = fcnt_reg;
    assign results.last        = last_reg;

endmodule

// File: hw/rtl/atbrm_checker.sv
// port-level checker of the block run mapper, bound to the top level
`include "atb_block_run_mapper_unit_defines.svh"

module atbrm_checker
    import atbrm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [KIND_W-1:0]  kind,
    input logic [IDX_W-1:0]   entry_index,
    input logic [BLOCK_W-1:0] phys_block,
    input logic [PAGE_W-1:0]  virt_page,
    input logic [MODE_W-1:0]  mode_word,
    input logic [IDX_W-1:0]   fill_count,
    input logic               last
);

    `ATBRM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(virt_page) && $stable(last), "result changed while stalled")

    `ATBRM_ASSERT_NOW(a_fail_shape, clk, rst_n, out_valid && (kind == KIND_FAIL), last && (entry_index == '0) && (phys_block == '0) && (virt_page == '0) && (mode_word == '0) && (fill_count == '0), "malformed failure item")

    `ATBRM_ASSERT_NOW(a_fill_shape, clk, rst_n, out_valid && (kind == KIND_FILL), last && (fill_count != '0) && (mode_word == MODE_BASE), "malformed fill item")

    `ATBRM_ASSERT_NOW(a_busy_no_input, clk, rst_n, out_valid && !last, !in_ready && (kind == KIND_ENTRY) && (fill_count == '0), "input taken during a run")

endmodule

bind atb_block_run_mapper_unit atbrm_checker u_atbrm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (blocks.ready),
    .out_valid   (results.valid),
    .out_ready   (results.ready),
    .kind        (results.kind),
    .entry_index (results.entry_index),
    .phys_block  (results.phys_block),
    .virt_page   (results.virt_page),
    .mode_word   (results.mode_word),
    .fill_count  (results.fill_count),
    .last        (results.last)
);

// File: bench/atb_block_run_mapper_unit_test.sv
// self-checking bench for the block run mapper: random and directed block lists vs. a predictor
module atb_block_run_mapper_unit_test;
    import atbrm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // drain wait after the last expected item
    localparam int unsigned DRAIN_CYCLES = 96;
    // generous bound on the whole run, well above the slowest legal schedule
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned PAGE_WRAP    = (1 << PAGE_W) - 1;
    localparam int unsigned RANDOM_PHASES = 12;
    localparam int unsigned PHASE_ITEMS  = 26;

    // one translation table write as seen on the result channel
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [IDX_W-1:0]   entry_index;
        logic [BLOCK_W-1:0] phys_block;
        logic [PAGE_W-1:0]  virt_page;
        logic [MODE_W-1:0]  mode_word;
        logic [IDX_W-1:0]   fill_count;
        logic               last;
    } table_write_t;

    logic clk;
    logic rst_n;

    atbrm_block_if  blk_if ();
    atbrm_result_if res_if ();
    atbrm_cfg_if    cfg_if ();

    atb_block_run_mapper_unit u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .blocks  (blk_if),
        .results (res_if),
        .cfg     (cfg_if)
    );

    // block numbers waiting to be offered, filled phase by phase
    logic [BLOCK_W-1:0] block_feed [$];
    // table writes predicted but not yet seen
    table_write_t       expected_writes [$];

    // predictor copy of the registers and the list buffer
    logic [PAGE_W-1:0]  map_base;
    logic [LIMIT_W-1:0] map_limit;
    logic [BLOCK_W-1:0] stored_blocks [LIST_DEPTH_DEF];
    int unsigned        stored_count;

    // pacing controls set per phase
    bit          quiet_mode;
    bit          pause_for_results;
    int unsigned feed_gap;
    int unsigned sink_stall;

    int unsigned  mismatch_count;
    int unsigned  cycle_count;
    table_write_t seen_write;
    table_write_t due_write;

    // free-running clock, 2 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // clamp the list limit register the way the block does
    function automatic int unsigned list_capacity(input logic [LIMIT_W-1:0] lim);
        if (lim < 1)
            return 1;
        if (lim > LIST_DEPTH_DEF)
            return LIST_DEPTH_DEF;
        return lim;
    endfunction

    // trailing zeros of a page, capped at the widest alignment
    function automatic int unsigned page_alignment(input int unsigned page);
        int unsigned zeros;
        zeros = 0;
        while (zeros < EXP_MAX && ((page >> zeros) & 1) == 0)
            zeros++;
        return zeros;
    endfunction

    function automatic void push_write(input logic [KIND_W-1:0] kind,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [BLOCK_W-1:0] phys,
                                       input logic [PAGE_W-1:0] page,
                                       input logic [MODE_W-1:0] mode,
                                       input logic [IDX_W-1:0] count);
        table_write_t w;
        w.kind        = kind;
        w.entry_index = idx;
        w.phys_block  = phys;
        w.virt_page   = page;
        w.mode_word   = mode;
        w.fill_count  = count;
        w.last        = 1'b0;
        expected_writes.push_back(w);
    endfunction

    // flag the final write of a run and empty the list
    function automatic void close_run();
        table_write_t tail;
        tail = expected_writes.pop_back();
        tail.last = 1'b1;
        expected_writes.push_back(tail);
        stored_count = 0;
    endfunction

    function automatic void push_failure();
        push_write(KIND_FAIL, '0, '0, '0, '0, '0);
        close_run();
    endfunction

    // expected table writes for one accepted block number
    function automatic void predict_mapping(input logic [BLOCK_W-1:0] blk);
        int unsigned        cap;
        int unsigned        tix;
        int unsigned        page;
        int unsigned        start;
        int unsigned        e;
        int unsigned        maxe;
        int unsigned        run_len;
        int unsigned        i;
        logic [BLOCK_W-1:0] phys;
        cap = list_capacity(map_limit);
        if (blk != '0)
        begin
            // one slot is kept for the terminator
            if (stored_count >= cap - 1)
                push_failure();
            else
            begin
                stored_blocks[stored_count] = blk;
                stored_count++;
            end
            return;
        end
        if (map_base == '0)
        begin
            push_failure();
            return;
        end
        // entry 0 sits one page below the base
        push_write(KIND_ENTRY, '0, '0, PAGE_W'((int'(map_base) - 1) & PAGE_WRAP),
                   MODE_FIRST, '0);
        tix   = 1;
        page  = map_base;
        start = 0;
        do
        begin
            maxe    = page_alignment(page);
            e       = 0;
            run_len = 1;
            i       = start;
            phys    = (start < stored_count) ? stored_blocks[start] : '0;
            // grow the run while blocks stay consecutive and the page allows it
            while (i + 1 < stored_count && e < maxe &&
                   {16'd0, stored_blocks[i]} + 32'd1 == {16'd0, stored_blocks[i + 1]})
            begin
                run_len++;
                if ((run_len & ((2 << e) - 1)) == 0)
                    e++;
                i++;
            end
            if (tix < TABLE_ENTRIES_DEF)
                push_write(KIND_ENTRY, IDX_W'(tix), phys, PAGE_W'(page),
                           MODE_BASE | MODE_W'(e), '0);
            tix++;
            page  = (page + (1 << e)) & PAGE_WRAP;
            start = start + (1 << e);
        end
        while (start < stored_count);
        if (tix < TABLE_ENTRIES_DEF)
            push_write(KIND_FILL, IDX_W'(tix),
                       (stored_count > 0) ? stored_blocks[0] : '0,
                       PAGE_W'(page), MODE_BASE, IDX_W'(TABLE_ENTRIES_DEF - tix));
        close_run();
    endfunction

    // block channel driver: predicts on every accepted item, then offers the next
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_if.valid        <= 1'b0;
            blk_if.block_number <= '0;
            feed_gap = 0;
        end
        else
        begin
            if (blk_if.valid && blk_if.ready)
                predict_mapping(blk_if.block_number);
            // only move on once the current item is gone
            if (!blk_if.valid || blk_if.ready)
            begin
                if (feed_gap > 0)
                begin
                    feed_gap--;
                    blk_if.valid <= 1'b0;
                end
                else if (block_feed.size() != 0 &&
                         !(pause_for_results && expected_writes.size() != 0))
                begin
                    blk_if.valid        <= 1'b1;
                    blk_if.block_number <= block_feed.pop_front();
                    feed_gap = quiet_mode ? 0 : $urandom_range(0, 8);
                end
                else
                    blk_if.valid <= 1'b0;
            end
        end
    end

    // result channel monitor: checks every accepted item and paces ready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_if.ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (res_if.valid && res_if.ready)
            begin
                seen_write.kind        = res_if.kind;
                seen_write.entry_index = res_if.entry_index;
                seen_write.phys_block  = res_if.phys_block;
                seen_write.virt_page   = res_if.virt_page;
                seen_write.mode_word   = res_if.mode_word;
                seen_write.fill_count  = res_if.fill_count;
                seen_write.last        = res_if.last;
                if (expected_writes.size() == 0)
                begin
                    if (mismatch_count < 10)
                        $display("[%0t] unexpected table write: kind %0d idx %0d phys %h page %h",
                                 $realtime, seen_write.kind, seen_write.entry_index,
                                 seen_write.phys_block, seen_write.virt_page);
                    mismatch_count++;
                end
                else
                begin
                    due_write = expected_writes.pop_front();
                    if (seen_write.kind        !== due_write.kind        ||
                        seen_write.entry_index !== due_write.entry_index ||
                        seen_write.phys_block  !== due_write.phys_block  ||
                        seen_write.virt_page   !== due_write.virt_page   ||
                        seen_write.mode_word   !== due_write.mode_word   ||
                        seen_write.fill_count  !== due_write.fill_count  ||
                        seen_write.last        !== due_write.last)
                    begin
                        if (mismatch_count < 10)
                        begin
                            $display("[%0t] table write mismatch", $realtime);
                            $display("    expected kind %0d idx %0d phys %h page %h mode %h fill %0d last %0d",
                                     due_write.kind, due_write.entry_index, due_write.phys_block,
                                     due_write.virt_page, due_write.mode_word,
                                     due_write.fill_count, due_write.last);
                            $display("    actual   kind %0d idx %0d phys %h page %h mode %h fill %0d last %0d",
                                     seen_write.kind, seen_write.entry_index, seen_write.phys_block,
                                     seen_write.virt_page, seen_write.mode_word,
                                     seen_write.fill_count, seen_write.last);
                        end
                        mismatch_count++;
                    end
                end
                sink_stall = quiet_mode ? 0 : $urandom_range(0, 8);
            end
            // stall countdown runs regardless of valid so gaps land anywhere
            if (sink_stall > 0)
            begin
                sink_stall--;
                res_if.ready <= 1'b0;
            end
            else
                res_if.ready <= 1'b1;
        end
    end

    // wait until every item is in, every write is out, and the walk has had time to finish
    task automatic settle();
        do
            @(posedge clk);
        while (block_feed.size() != 0 || blk_if.valid || expected_writes.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        if (idx == REG_BASE_PAGE)
            map_base = value[PAGE_W-1:0];
        else if (idx == REG_LIST_LIMIT)
            map_limit = value[LIMIT_W-1:0];
    endtask

    // registers change only with the block idle
    task automatic configure(input logic [PAGE_W-1:0] base, input logic [LIMIT_W-1:0] lim);
        settle();
        write_register(REG_BASE_PAGE, CFG_DATA_W'(base));
        write_register(REG_LIST_LIMIT, CFG_DATA_W'(lim));
    endtask

    // n nonzero blocks, mostly consecutive, sometimes close to the top of the range
    function automatic void feed_blocks(input int unsigned n);
        logic [BLOCK_W-1:0] blk;
        blk = BLOCK_W'($urandom_range(1, 65535));
        if ($urandom_range(0, 7) == 0)
            blk = 16'hFFFF - BLOCK_W'($urandom_range(0, 2 * n));
        for (int unsigned k = 0; k < n; k++)
        begin
            block_feed.push_back(blk);
            if ($urandom_range(0, 3) != 0)
                blk = blk + 1'b1;
            else
                blk = BLOCK_W'($urandom);
            // zero would end the list early
            if (blk == '0)
                blk = BLOCK_W'($urandom_range(1, 65535));
        end
    endfunction

    initial
    begin
        int unsigned        cap;
        int unsigned        pick;
        int unsigned        phase_start;
        logic [PAGE_W-1:0]  base_pick;
        logic [LIMIT_W-1:0] limit_pick;

        rst_n = 1'b0;
        cfg_if.valid <= 1'b0;
        cfg_if.index <= '0;
        cfg_if.data  <= '0;
        map_base          = BASE_PAGE_RST;
        map_limit         = LIMIT_RST;
        stored_count      = 0;
        quiet_mode        = 1'b0;
        pause_for_results = 1'b0;
        mismatch_count    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset values: empty list, then a list that does not wrap 0xffff into 1
        configure(18'd1, 6'd32);
        block_feed.push_back(16'h0000);
        block_feed.push_back(16'hFFFF);
        block_feed.push_back(16'h0001);
        block_feed.push_back(16'h0000);

        // base aligned to 16 pages lets a run of four share one entry
        configure(18'h00010, 6'd32);
        block_feed.push_back(16'h0100);
        block_feed.push_back(16'h0101);
        block_feed.push_back(16'h0102);
        block_feed.push_back(16'h0103);
        block_feed.push_back(16'hAAAA);
        block_feed.push_back(16'h0000);

        // base page zero fails setup, with and without blocks loaded
        configure(18'h00000, 6'd32);
        block_feed.push_back(16'h0000);
        block_feed.push_back(16'h5555);
        block_feed.push_back(16'h0000);

        // top page wraps to page 0, which has the widest alignment; oversized limit
        configure(18'h3FFFF, 6'd63);
        block_feed.push_back(16'h0007);
        block_feed.push_back(16'h0040);
        block_feed.push_back(16'h0041);
        block_feed.push_back(16'h0042);
        block_feed.push_back(16'h0000);

        // smallest legal list: overflow on the second block, then one block
        configure(18'h20000, 6'd2);
        block_feed.push_back(16'h8000);
        block_feed.push_back(16'h7FFF);
        block_feed.push_back(16'h0003);
        block_feed.push_back(16'h0000);

        // limit below one acts as one: only empty lists survive
        configure(18'h20000, 6'd0);
        block_feed.push_back(16'h0000);
        block_feed.push_back(16'h0009);

        // random phases with fresh settings each time
        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case ($urandom_range(0, 4))
                0: base_pick = PAGE_W'($urandom_range(1, PAGE_WRAP));
                1: base_pick = PAGE_W'(($urandom | 1) << $urandom_range(0, EXP_MAX));
                2: base_pick = PAGE_W'(PAGE_WRAP - $urandom_range(0, 40));
                3: base_pick = PAGE_W'(1 << $urandom_range(0, EXP_MAX));
                default: base_pick = 18'd1;
            endcase
            // one phase runs with setup always failing
            if (phase == 5)
                base_pick = '0;
            case ($urandom_range(0, 4))
                0: limit_pick = 6'd32;
                1: limit_pick = 6'd2;
                2, 3: limit_pick = LIMIT_W'($urandom_range(2, 32));
                default: limit_pick = LIMIT_W'($urandom_range(0, 63));
            endcase
            configure(base_pick, limit_pick);
            quiet_mode        = (phase % 4 == 3);
            // sender holds off until all writes of a run are back
            pause_for_results = (phase == 2);
            cap = list_capacity(limit_pick);
            phase_start = block_feed.size();
            while (block_feed.size() - phase_start < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    // overflow: one block too many
                    feed_blocks(cap);
                else if (pick < 4)
                    block_feed.push_back('0);
                else if (pick == 4)
                begin
                    // fullest list the limit allows
                    feed_blocks(cap - 1);
                    block_feed.push_back('0);
                end
                else
                begin
                    feed_blocks((cap > 1) ? $urandom_range(1, cap - 1) : 0);
                    block_feed.push_back('0);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && expected_writes.size() == 0)
            $display("atb_block_run_mapper_unit verification clean");
        else
            $display("atb_block_run_mapper_unit verification failed");
        $finish;
    end

    // watchdog on the whole run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("atb_block_run_mapper_unit verification failed");
        $finish;
    end

endmodule
